FILE: hw/rtl/cpffa_pkg.sv
package cpffa_pkg;

  localparam int NUM_POOLS        = 16;
  localparam int MAX_OBJECTS      = 16384;
  localparam int EXTENTS_PER_POOL = 256;
  localparam int POOL_VERTICES    = 65535;

  localparam int POOL_W    = $clog2(NUM_POOLS);
  localparam int OBJ_W     = $clog2(MAX_OBJECTS);
  localparam int EXT_IDX_W = $clog2(EXTENTS_PER_POOL);
  localparam int EXT_CNT_W = EXT_IDX_W + 1;
  localparam int EXT_ADR_W = POOL_W + EXT_IDX_W;
  localparam int EXT_DEPTH = NUM_POOLS * EXTENTS_PER_POOL;

  localparam int ID_W   = 14;
  localparam int CLS_W  = 8;
  localparam int VERT_W = 16;
  localparam int FREE_W = VERT_W + 1;
  localparam int CFG_W  = 15;

  localparam logic [CFG_W-1:0]  OBJ_COUNT_RESET = CFG_W'(16384);
  localparam logic [VERT_W-1:0] BIG_ZERO_LIMIT  = VERT_W'(100);
  localparam logic [CLS_W-1:0]  DEFAULT_CLASS   = CLS_W'(7);
  localparam logic [FREE_W-1:0] BUF_END         = FREE_W'(POOL_VERTICES);
  localparam logic [FREE_W-1:0] FREE_RESET      = FREE_W'(POOL_VERTICES + 1);
  localparam logic [VERT_W+1:0] RANGE_LAST      = 18'h0ffff;

  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_BADID    = 3'd4,
    ST_ABSENT   = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_REL_START,
    OP_POOL_START,
    OP_POOL,
    OP_NEXT_POOL,
    OP_EXT_RD,
    OP_SCAN_EV,
    OP_INS_START,
    OP_INS_RD,
    OP_INS_WR,
    OP_INS_PUT,
    OP_REL_EV,
    OP_SHD_RD,
    OP_SHD_WR,
    OP_REL_FIN,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic bad_id;
    logic is_release;
    logic rec_valid;
    logic big0;
    logic eligible;
    logic cnt_zero;
    logic last_pool;
    logic scan_found;
    logic scan_last;
    logic range_over;
    logic ins_done;
    logic rel_end;
    logic match;
    logic shd_done;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic              valid;
    logic [POOL_W-1:0] pool;
    logic [VERT_W-1:0] base;
    logic [VERT_W-1:0] size;
  } rec_t;

  typedef struct packed {
    logic [VERT_W-1:0] start;
    logic [VERT_W-1:0] len;
  } ext_t;

endpackage

FILE: hw/rtl/cpffa_dp.sv
module cpffa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cpffa_pkg::cmd_t               cmd,
  output cpffa_pkg::sts_t               sts,
  input  logic                          action,
  input  logic [cpffa_pkg::ID_W-1:0]    object_id,
  input  logic [cpffa_pkg::CLS_W-1:0]   class_mask,
  input  logic [cpffa_pkg::VERT_W-1:0]  vertex_count,
  input  logic                          cfg_we,
  input  logic [cpffa_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [cpffa_pkg::POOL_W-1:0]  pool_index,
  output logic [cpffa_pkg::VERT_W-1:0]  base_offset
);

  logic [cpffa_pkg::CFG_W-1:0]     obj_count;
  logic                            req_action;
  logic [cpffa_pkg::ID_W-1:0]      req_id;
  logic [cpffa_pkg::CLS_W-1:0]     req_cls;
  logic [cpffa_pkg::VERT_W-1:0]    req_n;

  cpffa_pkg::rec_t                 rec_mem [cpffa_pkg::MAX_OBJECTS];
  cpffa_pkg::rec_t                 rec_q;
  cpffa_pkg::rec_t                 rec_wdata;
  logic [cpffa_pkg::OBJ_W-1:0]     rec_waddr;
  logic                            rec_we;
  logic [cpffa_pkg::OBJ_W-1:0]     clr_addr;

  cpffa_pkg::ext_t                 ext_mem [cpffa_pkg::EXT_DEPTH];
  cpffa_pkg::ext_t                 ext_q;
  cpffa_pkg::ext_t                 ext_wdata;
  logic [cpffa_pkg::EXT_CNT_W-1:0] ext_ridx;
  logic [cpffa_pkg::EXT_CNT_W-1:0] ext_widx;
  logic                            ext_re;
  logic                            ext_we;

  logic [cpffa_pkg::EXT_CNT_W-1:0] ext_cnt    [cpffa_pkg::NUM_POOLS];
  logic [cpffa_pkg::CLS_W-1:0]     pool_class [cpffa_pkg::NUM_POOLS];
  logic [cpffa_pkg::FREE_W-1:0]    pool_free  [cpffa_pkg::NUM_POOLS];

  logic [cpffa_pkg::POOL_W-1:0]    p;
  logic [cpffa_pkg::EXT_CNT_W-1:0] idx;
  logic [cpffa_pkg::EXT_CNT_W-1:0] slot;
  logic [cpffa_pkg::FREE_W-1:0]    prev_end;
  logic [cpffa_pkg::FREE_W-1:0]    hole_base;
  logic                            matched;

  logic [cpffa_pkg::EXT_CNT_W-1:0] cur_cnt;
  logic [cpffa_pkg::CLS_W-1:0]     cur_cls;
  logic [cpffa_pkg::FREE_W-1:0]    cur_free;
  logic [cpffa_pkg::CLS_W-1:0]     bound_cls;
  logic [cpffa_pkg::FREE_W-1:0]    n_ext;
  logic [cpffa_pkg::FREE_W-1:0]    ext_start;
  logic [cpffa_pkg::FREE_W-1:0]    gap;
  logic [cpffa_pkg::FREE_W-1:0]    new_end;
  logic                            gap_hit;
  logic                            tail_hit;
  logic                            scan_last;
  logic                            range_over;

  assign cur_cnt   = ext_cnt[p];
  assign cur_cls   = pool_class[p];
  assign cur_free  = pool_free[p];
  assign bound_cls = (cur_cls == '0) ? req_cls : cur_cls;
  assign n_ext     = {1'b0, req_n};
  assign ext_start = {1'b0, ext_q.start};
  assign gap       = (ext_start > prev_end) ? (ext_start - prev_end) : '0;
  assign gap_hit   = (gap >= n_ext);
  assign new_end   = ext_start + {1'b0, ext_q.len};
  // The last extent's trailing hole runs up to the end of the vertex buffer.
  assign tail_hit  = (new_end < cpffa_pkg::BUF_END) &&
                     ((cpffa_pkg::BUF_END - new_end) >= n_ext);
  assign scan_last = (idx == (cur_cnt - 1'b1));
  assign range_over = ({1'b0, hole_base} + {2'b00, req_n}) > cpffa_pkg::RANGE_LAST;

  always_comb begin
    sts.clr_done   = (clr_addr == cpffa_pkg::OBJ_W'(cpffa_pkg::MAX_OBJECTS - 1));
    sts.bad_id     = ({1'b0, req_id} >= obj_count);
    sts.is_release = req_action;
    sts.rec_valid  = rec_q.valid;
    sts.big0       = (req_id == '0) && (req_n > cpffa_pkg::BIG_ZERO_LIMIT);
    sts.eligible   = ((bound_cls & req_cls) != '0) && (cur_free >= n_ext) &&
                     (cur_cnt < cpffa_pkg::EXT_CNT_W'(cpffa_pkg::EXTENTS_PER_POOL));
    sts.cnt_zero   = (cur_cnt == '0);
    sts.last_pool  = (p == cpffa_pkg::POOL_W'(cpffa_pkg::NUM_POOLS - 1));
    sts.scan_found = gap_hit || (scan_last && tail_hit);
    sts.scan_last  = scan_last;
    sts.range_over = range_over;
    sts.ins_done   = (idx == slot);
    sts.rel_end    = (idx >= cur_cnt);
    sts.match      = (ext_q.start == rec_q.base) && (ext_q.len == rec_q.size);
    sts.shd_done   = ((idx + 1'b1) >= cur_cnt);
    sts.out_busy   = out_valid && out_stall;
  end

  // Object record port: clearing pass, allocation and release.
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = req_id;
    rec_wdata = '0;
    unique case (cmd.op)
      cpffa_pkg::OP_CLEAR: begin
        rec_we    = 1'b1;
        rec_waddr = clr_addr;
      end
      cpffa_pkg::OP_INS_PUT: begin
        rec_we          = 1'b1;
        rec_wdata.valid = 1'b1;
        rec_wdata.pool  = p;
        rec_wdata.base  = hole_base[cpffa_pkg::VERT_W-1:0];
        rec_wdata.size  = req_n;
      end
      cpffa_pkg::OP_REL_FIN: begin
        rec_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (cmd.op == cpffa_pkg::OP_LOAD) begin
      rec_q <= rec_mem[object_id];
    end
  end

  // Extent list port: scan reads, shifts up on insert and down on removal.
  always_comb begin
    ext_re    = 1'b0;
    ext_we    = 1'b0;
    ext_ridx  = idx;
    ext_widx  = idx;
    ext_wdata = ext_q;
    unique case (cmd.op)
      cpffa_pkg::OP_EXT_RD: ext_re = 1'b1;
      cpffa_pkg::OP_INS_RD: begin
        ext_re   = 1'b1;
        ext_ridx = idx - 1'b1;
      end
      cpffa_pkg::OP_SHD_RD: begin
        ext_re   = 1'b1;
        ext_ridx = idx + 1'b1;
      end
      cpffa_pkg::OP_INS_WR, cpffa_pkg::OP_SHD_WR: ext_we = 1'b1;
      cpffa_pkg::OP_INS_PUT: begin
        ext_we          = 1'b1;
        ext_widx        = slot;
        ext_wdata.start = hole_base[cpffa_pkg::VERT_W-1:0];
        ext_wdata.len   = req_n;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ext_we) begin
      ext_mem[{p, ext_widx[cpffa_pkg::EXT_IDX_W-1:0]}] <= ext_wdata;
    end
    if (ext_re) begin
      ext_q <= ext_mem[{p, ext_ridx[cpffa_pkg::EXT_IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_count <= cpffa_pkg::OBJ_COUNT_RESET;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < cpffa_pkg::NUM_POOLS; i++) begin
        ext_cnt[i]    <= '0;
        pool_class[i] <= '0;
        pool_free[i]  <= cpffa_pkg::FREE_RESET;
      end
    end else begin
      if (cfg_we) begin
        obj_count <= cfg_wdata;
      end
      if (cmd.op == cpffa_pkg::OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        cpffa_pkg::OP_CLEAR: clr_addr <= clr_addr + 1'b1;
        cpffa_pkg::OP_POOL:  pool_class[p] <= bound_cls;
        cpffa_pkg::OP_INS_PUT: begin
          ext_cnt[p]   <= cur_cnt + 1'b1;
          pool_free[p] <= cur_free - n_ext;
        end
        cpffa_pkg::OP_REL_FIN: begin
          if (matched) begin
            ext_cnt[p] <= cur_cnt - 1'b1;
          end
          pool_free[p] <= cur_free + {1'b0, rec_q.size};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      cpffa_pkg::OP_LOAD: begin
        req_action <= action;
        req_id     <= object_id;
        req_cls    <= (class_mask == '0) ? cpffa_pkg::DEFAULT_CLASS : class_mask;
        req_n      <= vertex_count;
      end
      cpffa_pkg::OP_REL_START: begin
        p       <= rec_q.pool;
        idx     <= '0;
        matched <= 1'b0;
      end
      cpffa_pkg::OP_POOL_START: p <= '0;
      cpffa_pkg::OP_POOL: begin
        idx       <= '0;
        slot      <= '0;
        prev_end  <= '0;
        hole_base <= '0;
      end
      cpffa_pkg::OP_NEXT_POOL: p <= p + 1'b1;
      cpffa_pkg::OP_SCAN_EV: begin
        if (gap_hit) begin
          slot      <= idx;
          hole_base <= prev_end;
        end else if (scan_last && tail_hit) begin
          slot      <= idx + 1'b1;
          hole_base <= new_end;
        end
        prev_end <= new_end;
        idx      <= idx + 1'b1;
      end
      cpffa_pkg::OP_INS_START: idx <= cur_cnt;
      cpffa_pkg::OP_INS_WR:    idx <= idx - 1'b1;
      cpffa_pkg::OP_REL_EV: begin
        if (sts.match) begin
          matched <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      cpffa_pkg::OP_SHD_WR: idx <= idx + 1'b1;
      cpffa_pkg::OP_RESULT: begin
        status <= cmd.code;
        unique case (cmd.code)
          cpffa_pkg::ST_ALLOC: begin
            pool_index  <= p;
            base_offset <= hole_base[cpffa_pkg::VERT_W-1:0];
          end
          cpffa_pkg::ST_PRESENT, cpffa_pkg::ST_RELEASED: begin
            pool_index  <= rec_q.pool;
            base_offset <= rec_q.base;
          end
          default: begin
            pool_index  <= '0;
            base_offset <= '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.op == cpffa_pkg::OP_POOL |->
      cur_cnt <= cpffa_pkg::EXT_CNT_W'(cpffa_pkg::EXTENTS_PER_POOL))
    else $error("extent count of the current pool exceeds the list size");

  a_put_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.op == cpffa_pkg::OP_INS_PUT |-> !range_over && (slot <= cur_cnt))
    else $error("extent inserted past the buffer end or past the list");

  a_shift_in_list: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == cpffa_pkg::OP_INS_WR || cmd.op == cpffa_pkg::OP_SHD_WR) |->
      idx <= cur_cnt)
    else $error("extent shift writes outside the list");

endmodule

FILE: hw/rtl/cpffa_ctrl.sv
module cpffa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cpffa_pkg::sts_t sts,
  output cpffa_pkg::cmd_t cmd
);

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_LOOK    = 15'b000000000000100,
    S_POOL    = 15'b000000000001000,
    S_NEXT    = 15'b000000000010000,
    S_SCAN_RD = 15'b000000000100000,
    S_SCAN_EV = 15'b000000001000000,
    S_CHK     = 15'b000000010000000,
    S_INS_RD  = 15'b000000100000000,
    S_INS_WR  = 15'b000001000000000,
    S_REL_RD  = 15'b000010000000000,
    S_REL_EV  = 15'b000100000000000,
    S_SHD_RD  = 15'b001000000000000,
    S_SHD_WR  = 15'b010000000000000,
    S_RESP    = 15'b100000000000000
  } state_t;

  state_t              state;
  state_t              state_next;
  cpffa_pkg::status_t  code;
  cpffa_pkg::status_t  code_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd.op     = cpffa_pkg::OP_IDLE;
    cmd.code   = code;
    unique case (state)
      S_CLEAR: begin
        cmd.op = cpffa_pkg::OP_CLEAR;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = cpffa_pkg::OP_LOAD;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        priority if (sts.bad_id) begin
          code_next  = cpffa_pkg::ST_BADID;
          state_next = S_RESP;
        end else if (sts.is_release) begin
          if (!sts.rec_valid) begin
            code_next  = cpffa_pkg::ST_ABSENT;
            state_next = S_RESP;
          end else begin
            cmd.op     = cpffa_pkg::OP_REL_START;
            state_next = S_REL_RD;
          end
        end else if (sts.big0) begin
          code_next  = cpffa_pkg::ST_BADID;
          state_next = S_RESP;
        end else if (sts.rec_valid) begin
          code_next  = cpffa_pkg::ST_PRESENT;
          state_next = S_RESP;
        end else begin
          cmd.op     = cpffa_pkg::OP_POOL_START;
          state_next = S_POOL;
        end
      end
      S_POOL: begin
        // The pool binds to the request's class here even if it is then skipped.
        cmd.op = cpffa_pkg::OP_POOL;
        priority if (!sts.eligible) begin
          state_next = S_NEXT;
        end else if (sts.cnt_zero) begin
          state_next = S_CHK;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_NEXT: begin
        if (sts.last_pool) begin
          code_next  = cpffa_pkg::ST_NOSPACE;
          state_next = S_RESP;
        end else begin
          cmd.op     = cpffa_pkg::OP_NEXT_POOL;
          state_next = S_POOL;
        end
      end
      S_SCAN_RD: begin
        cmd.op     = cpffa_pkg::OP_EXT_RD;
        state_next = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.op = cpffa_pkg::OP_SCAN_EV;
        priority if (sts.scan_found) begin
          state_next = S_CHK;
        end else if (sts.scan_last) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_CHK: begin
        // A hole that ends past the last vertex ends the whole search.
        if (sts.range_over) begin
          code_next  = cpffa_pkg::ST_NOSPACE;
          state_next = S_RESP;
        end else begin
          cmd.op     = cpffa_pkg::OP_INS_START;
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts.ins_done) begin
          cmd.op     = cpffa_pkg::OP_INS_PUT;
          code_next  = cpffa_pkg::ST_ALLOC;
          state_next = S_RESP;
        end else begin
          cmd.op     = cpffa_pkg::OP_INS_RD;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.op     = cpffa_pkg::OP_INS_WR;
        state_next = S_INS_RD;
      end
      S_REL_RD: begin
        if (sts.rel_end) begin
          cmd.op     = cpffa_pkg::OP_REL_FIN;
          code_next  = cpffa_pkg::ST_RELEASED;
          state_next = S_RESP;
        end else begin
          cmd.op     = cpffa_pkg::OP_EXT_RD;
          state_next = S_REL_EV;
        end
      end
      S_REL_EV: begin
        cmd.op     = cpffa_pkg::OP_REL_EV;
        state_next = sts.match ? S_SHD_RD : S_REL_RD;
      end
      S_SHD_RD: begin
        if (sts.shd_done) begin
          cmd.op     = cpffa_pkg::OP_REL_FIN;
          code_next  = cpffa_pkg::ST_RELEASED;
          state_next = S_RESP;
        end else begin
          cmd.op     = cpffa_pkg::OP_SHD_RD;
          state_next = S_SHD_WR;
        end
      end
      S_SHD_WR: begin
        cmd.op     = cpffa_pkg::OP_SHD_WR;
        state_next = S_SHD_RD;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.op     = cpffa_pkg::OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
    code <= code_next;
  end

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == cpffa_pkg::OP_RESULT |-> !sts.out_busy)
    else $error("result loaded over an item still waiting at the output");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> state == S_CLEAR)
    else $error("reset did not start the record clearing pass");

  a_look_after_load: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |-> $past(cmd.op) == cpffa_pkg::OP_LOAD)
    else $error("record examined without a load");

endmodule

FILE: hw/rtl/class_pooled_first_fit_allocator_unit.sv
// Class-pooled first-fit vertex range allocator.
// Input channel (in_valid / in_stall) carries one request item: action 0
// allocates vertex_count vertices for object_id in a pool whose class meets
// class_mask, action 1 releases the object's range. Every item gives exactly
// one result item on the output channel (out_valid / out_stall): status,
// pool_index and base_offset.
// One item is worked at a time. A rejected, present or absent request goes from
// the lookup state straight to the result state. An allocation visits the pools
// in turn and reads and checks each extent of an eligible pool, then moves the
// extents after the hole up to make room; one that finds no room ends at the
// last pool or at a hole past the last vertex. A release scans the pool's
// extents for its range and moves the later extents down.
// A finished result waits in the output register while out_stall is high;
// the next item is already accepted, and its result waits until the register
// is free. cfg_we writes the object id limit; the user must do so only while
// the block is idle; the block does not enforce it. After rst it clears the
// 16384 object records, one per cycle, and holds in_stall high until done.
module class_pooled_first_fit_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [cpffa_pkg::ID_W-1:0]    object_id,
  input  logic [cpffa_pkg::CLS_W-1:0]   class_mask,
  input  logic [cpffa_pkg::VERT_W-1:0]  vertex_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [cpffa_pkg::POOL_W-1:0]  pool_index,
  output logic [cpffa_pkg::VERT_W-1:0]  base_offset,
  input  logic                          cfg_we,
  input  logic [cpffa_pkg::CFG_W-1:0]   cfg_wdata
);

  cpffa_pkg::cmd_t cmd;
  cpffa_pkg::sts_t sts;

  cpffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpffa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (action),
    .object_id    (object_id),
    .class_mask   (class_mask),
    .vertex_count (vertex_count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .pool_index   (pool_index),
    .base_offset  (base_offset)
  );

endmodule

FILE: sim/class_pooled_first_fit_allocator_checker.sv
`timescale 1ns / 1ps
module class_pooled_first_fit_allocator_checker
  import cpffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              action,
  input  logic [ID_W-1:0]   object_id,
  input  logic [CLS_W-1:0]  class_mask,
  input  logic [VERT_W-1:0] vertex_count,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        status,
  input  logic [POOL_W-1:0] pool_index,
  input  logic [VERT_W-1:0] base_offset,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    status_t           st;
    logic [POOL_W-1:0] pool;
    logic [VERT_W-1:0] base;
  } range_result_t;

  range_result_t expected_ranges[$];

  bit                obj_live [MAX_OBJECTS];
  logic [POOL_W-1:0] obj_pool [MAX_OBJECTS];
  int                obj_base [MAX_OBJECTS];
  int                obj_size [MAX_OBJECTS];
  int                ext_start [NUM_POOLS][EXTENTS_PER_POOL];
  int                ext_len [NUM_POOLS][EXTENTS_PER_POOL];
  int                ext_num [NUM_POOLS];
  int                pool_cls [NUM_POOLS];
  int                pool_room [NUM_POOLS];
  int                id_limit;

  function automatic range_result_t mk(status_t st, int p, int b);
    range_result_t r;
    r.st = st;
    r.pool = p[POOL_W-1:0];
    r.base = b[VERT_W-1:0];
    return r;
  endfunction

  function automatic range_result_t allocate_or_release(bit rel, int id, int cls, int n);
    int p, cnt, k, slot, base, fin, lim, gap;
    bit found;
    if (id >= id_limit || id >= MAX_OBJECTS) return mk(ST_BADID, 0, 0);
    if (rel) begin
      if (!obj_live[id]) return mk(ST_ABSENT, 0, 0);
      p = obj_pool[id];
      cnt = ext_num[p];
      for (k = 0; k < cnt; k++) begin
        if (ext_start[p][k] == obj_base[id] && ext_len[p][k] == obj_size[id]) begin
          for (int j = k; j < cnt - 1; j++) begin
            ext_start[p][j] = ext_start[p][j+1];
            ext_len[p][j] = ext_len[p][j+1];
          end
          ext_num[p] = cnt - 1;
          break;
        end
      end
      pool_room[p] = (pool_room[p] + obj_size[id]) & 'h1ffff;
      obj_live[id] = 0;
      return mk(ST_RELEASED, p, obj_base[id]);
    end
    // Object zero may only hold small ranges, whether or not it is present.
    if (id == 0 && n > 100) return mk(ST_BADID, 0, 0);
    if (obj_live[id]) return mk(ST_PRESENT, obj_pool[id], obj_base[id]);
    if (cls == 0) cls = DEFAULT_CLASS;
    for (p = 0; p < NUM_POOLS; p++) begin
      if (pool_cls[p] == 0) pool_cls[p] = cls;
      if ((pool_cls[p] & cls) == 0) continue;
      if (pool_room[p] < n) continue;
      cnt = ext_num[p];
      if (cnt >= EXTENTS_PER_POOL) continue;
      found = 0;
      slot = 0;
      base = 0;
      if (cnt == 0) found = (n <= POOL_VERTICES);
      else if (ext_start[p][0] >= n) found = 1;
      else begin
        for (k = 0; k < cnt; k++) begin
          fin = ext_start[p][k] + ext_len[p][k];
          lim = (k + 1 < cnt) ? ext_start[p][k+1] : POOL_VERTICES;
          gap = (lim > fin) ? lim - fin : 0;
          if (gap >= n) begin
            found = 1;
            slot = k + 1;
            base = fin;
            break;
          end
        end
      end
      if (!found) continue;
      if (base + n > 'hffff) return mk(ST_NOSPACE, 0, 0);
      for (int j = cnt; j > slot; j--) begin
        ext_start[p][j] = ext_start[p][j-1];
        ext_len[p][j] = ext_len[p][j-1];
      end
      ext_start[p][slot] = base;
      ext_len[p][slot] = n;
      ext_num[p] = cnt + 1;
      pool_room[p] -= n;
      obj_live[id] = 1;
      obj_pool[id] = p[POOL_W-1:0];
      obj_base[id] = base;
      obj_size[id] = n;
      return mk(ST_ALLOC, p, base);
    end
    return mk(ST_NOSPACE, 0, 0);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    range_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_OBJECTS; i++) obj_live[i] = 0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        ext_num[p] = 0;
        pool_cls[p] = 0;
        pool_room[p] = POOL_VERTICES + 1;
      end
      id_limit = OBJ_COUNT_RESET;
      expected_ranges.delete();
    end else begin
      if (cfg_we) id_limit = cfg_wdata;
      if (in_valid && !in_stall)
        expected_ranges.push_back(allocate_or_release(action, object_id, class_mask,
                                                      vertex_count));
      if (out_valid && !out_stall) begin
        if (expected_ranges.size() == 0) begin
          report_mismatch("result items expected", 1, 0);
        end else begin
          want = expected_ranges.pop_front();
          if (status != want.st) report_mismatch("status", status, want.st);
          if (pool_index != want.pool) report_mismatch("pool_index", pool_index, want.pool);
          if (base_offset != want.base) report_mismatch("base_offset", base_offset, want.base);
        end
      end
    end
    outstanding = expected_ranges.size();
  end

endmodule

FILE: sim/class_pooled_first_fit_allocator_unit_test.sv
`timescale 1ns / 1ps
module class_pooled_first_fit_allocator_unit_test;
  import cpffa_pkg::*;

  localparam int STALL_LIMIT = 60000;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              action = 1'b0;
  logic [ID_W-1:0]   object_id = '0;
  logic [CLS_W-1:0]  class_mask = '0;
  logic [VERT_W-1:0] vertex_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [POOL_W-1:0] pool_index;
  logic [VERT_W-1:0] base_offset;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int send_gap_pct = 0;
  int rx_stall_pct = 0;
  bit start_hold = 0;
  bit hold_taken = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  class_pooled_first_fit_allocator_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .object_id(object_id), .class_mask(class_mask),
    .vertex_count(vertex_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .pool_index(pool_index), .base_offset(base_offset),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  class_pooled_first_fit_allocator_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .object_id(object_id), .class_mask(class_mask),
    .vertex_count(vertex_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .pool_index(pool_index), .base_offset(base_offset),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The long hold is timed here so that the sender keeps offering items meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (start_hold && !hold_taken) begin
      out_stall <= 1'b1;
      hold_taken <= 1;
      hold_left <= 400;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(bit act, int id, int cls, int n);
    int g;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      g = $urandom_range(1, 6);
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    object_id <= id[ID_W-1:0];
    class_mask <= cls[CLS_W-1:0];
    vertex_count <= n[VERT_W-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_object_limit(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int id, cls, n;
    id = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(47);
    if ($urandom_range(99) < 35) begin
      offer(1, id, $urandom_range(255), $urandom_range(65535));
    end else begin
      case ($urandom_range(4))
        0: cls = 0;
        1: cls = 1 << $urandom_range(7);
        default: cls = $urandom_range(255);
      endcase
      case ($urandom_range(9))
        0: n = $urandom_range(65535);
        1: n = $urandom_range(101, 65535);
        2: n = 0;
        default: n = $urandom_range(1, 2500);
      endcase
      offer(0, id, cls, n);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed items: limits of the fields and the corner behaviors.
    offer(0, 0, 0, 100);
    offer(0, 0, 0, 101);
    offer(0, 0, 8'h01, 65535);
    offer(1, 0, 0, 0);
    offer(1, 0, 0, 0);
    offer(0, 1, 0, 0);
    offer(0, 1, 8'h02, 5);
    offer(0, 2, 8'h80, 65535);
    offer(0, 3, 8'hff, 65535);
    offer(0, 4, 8'h80, 1);
    offer(0, 5, 8'h07, 300);
    offer(0, 6, 8'h07, 200);
    offer(1, 5, 8'hff, 65535);
    offer(0, 7, 8'h07, 250);
    offer(0, 16383, 8'hff, 12);
    offer(1, 16383, 0, 0);
    offer(1, 9, 0, 0);
    offer(0, 8, 8'h55, 65535);
    offer(0, 9, 8'haa, 0);
    offer(1, 2, 0, 0);
    offer(0, 10, 8'h80, 65535);

    // Fill one pool's extent list so the next requests must skip it.
    for (int i = 0; i < 270; i++) offer(0, 1000 + i, 8'h40, 1);
    for (int i = 0; i < 20; i++) offer(1, 1000 + $urandom_range(269), 0, 0);

    set_object_limit(0);
    offer(0, 0, 0, 0);
    offer(1, 1, 0, 0);
    set_object_limit(32767);
    offer(0, 11, 8'h01, 40);
    set_object_limit(1);
    offer(0, 1, 0, 1);
    offer(0, 0, 0, 1);

    set_object_limit(16384);
    send_gap_pct <= 24;
    rx_stall_pct <= 73;
    for (int i = 0; i < 290; i++) random_item();

    set_object_limit(40);
    send_gap_pct <= 73;
    rx_stall_pct <= 24;
    for (int i = 0; i < 290; i++) random_item();

    set_object_limit(32767);
    send_gap_pct <= 0;
    rx_stall_pct <= 0;
    start_hold <= 1;
    for (int i = 0; i < 260; i++) random_item();

    set_object_limit(16384);
    for (int i = 0; i < 10; i++) random_item();

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cpffa_pkg.sv
hw/rtl/cpffa_dp.sv
hw/rtl/cpffa_ctrl.sv
hw/rtl/class_pooled_first_fit_allocator_unit.sv
sim/class_pooled_first_fit_allocator_checker.sv
sim/class_pooled_first_fit_allocator_unit_test.sv
